/* hdl/apm_pkg.sv */
// shared types, widths and command codes for the prefix-match address table
package apm_pkg;

  localparam int CMD_W    = 2;
  localparam int IP_W     = 32;
  localparam int PREFIX_W = 6;
  localparam int HW_W     = 48;

  localparam int DEFAULT_TABLE_DEPTH = 32;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [PREFIX_W-1:0] HOST_PREFIX = 6'd1;

  typedef struct packed {
    logic [IP_W-1:0]     ip;
    logic [IP_W-1:0]     mask;
    logic [IP_W-1:0]     net;
    logic [PREFIX_W-1:0] prefix;
    logic [HW_W-1:0]     hw;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

/* hdl/apm_req_if.sv */
// request channel: command, address and entry fields
interface apm_req_if;
  import apm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IP_W-1:0]     ip_addr;
  logic [IP_W-1:0]     net_mask;
  logic [IP_W-1:0]     net_value;
  logic [PREFIX_W-1:0] prefix_len;
  logic [HW_W-1:0]     hw_addr_in;

  modport source (
    output valid, cmd, ip_addr, net_mask, net_value, prefix_len, hw_addr_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, ip_addr, net_mask, net_value, prefix_len, hw_addr_in,
    output ready
  );
endinterface

/* hdl/apm_rsp_if.sv */
// response channel: lookup result and append status
interface apm_rsp_if;
  import apm_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [HW_W-1:0] hw_addr_out;
  logic            table_full;

  modport source (
    output valid, found, hw_addr_out, table_full,
    input  ready
  );
  modport sink (
    input  valid, found, hw_addr_out, table_full,
    output ready
  );
endinterface

/* hdl/apm_ram.sv */
// generic single-write, single-read ram with registered read data
module apm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/arp_prefix_match_lookup.sv */
// address table with host and longest-prefix lookup over a shared compare unit
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, ip_addr, net_mask, net_value, prefix_len, hw_addr_in
//   rsp      out  valid/ready    found, hw_addr_out, table_full
//
// append, clear and unused commands answer in the cycle after the request beat
// a lookup reads one entry per cycle from the table ram and runs it through a
// single masked compare; the scan ends early on a host hit
// req.ready is low while a lookup runs and while a response beat is pending
// rst is synchronous and empties the table; no clearing pass is needed
module arp_prefix_match_lookup #(
  parameter int TABLE_DEPTH = apm_pkg::DEFAULT_TABLE_DEPTH
) (
  input logic      clk,
  input logic      rst,
  apm_req_if.sink  req,
  apm_rsp_if.source rsp
);
  import apm_pkg::*;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t state, state_next;

  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    scan_idx, scan_idx_next;
  logic                pend, pend_next;
  logic [IP_W-1:0]     addr, addr_next;
  logic                hit, hit_next;
  logic [PREFIX_W-1:0] best, best_next;
  logic [HW_W-1:0]     hw_best, hw_best_next;

  logic            out_valid, out_valid_next;
  logic            out_found, out_found_next;
  logic [HW_W-1:0] out_hw, out_hw_next;
  logic            out_full, out_full_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ent;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_beat, out_beat, has_room, more, scan_end;
  logic is_host, host_hit, net_win;

  apm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_beat  = req.valid && req.ready;
  assign out_beat = out_valid && rsp.ready;
  assign has_room = count < CNT_W'(TABLE_DEPTH);
  assign more     = scan_idx < count;
  assign ent      = entry_t'(ram_rdata);

  // shared compare unit: one entry per cycle
  assign is_host  = ent.prefix == HOST_PREFIX;
  assign host_hit = pend && is_host && (ent.ip == addr);
  assign net_win  = pend && !is_host && ((addr & ent.mask) == ent.net) && (ent.prefix > best);
  assign scan_end = host_hit || !more;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat && req.cmd == CMD_LOOKUP) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = !out_valid;
        ram_we    = in_beat && req.cmd == CMD_APPEND && has_room;
      end
      ST_SCAN: begin
        ram_re = more && !host_hit;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign ram_waddr        = count[ADDR_W-1:0];
  assign ram_raddr        = scan_idx[ADDR_W-1:0];
  assign ram_wdata.ip     = req.ip_addr;
  assign ram_wdata.mask   = req.net_mask;
  assign ram_wdata.net    = req.net_value;
  assign ram_wdata.prefix = req.prefix_len;
  assign ram_wdata.hw     = req.hw_addr_in;

  // datapath next values
  always_comb begin
    count_next     = count;
    scan_idx_next  = scan_idx;
    pend_next      = 1'b0;
    addr_next      = addr;
    hit_next       = hit;
    best_next      = best;
    hw_best_next   = hw_best;
    out_valid_next = out_valid && !out_beat;
    out_found_next = out_found;
    out_hw_next    = out_hw;
    out_full_next  = out_full;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          out_found_next = 1'b0;
          out_hw_next    = '0;
          out_full_next  = 1'b0;
          case (req.cmd)
            CMD_LOOKUP: begin
              addr_next     = req.ip_addr;
              scan_idx_next = '0;
              hit_next      = 1'b0;
              best_next     = '0;
              hw_best_next  = '0;
            end
            CMD_APPEND: begin
              out_valid_next = 1'b1;
              if (has_room) begin
                count_next = count + CNT_W'(1);
              end else begin
                out_full_next = 1'b1;
              end
            end
            CMD_CLEAR: begin
              out_valid_next = 1'b1;
              count_next     = '0;
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (net_win) begin
          hit_next     = 1'b1;
          best_next    = ent.prefix;
          hw_best_next = ent.hw;
        end
        if (scan_end) begin
          out_valid_next = 1'b1;
          out_full_next  = 1'b0;
          if (host_hit || net_win) begin
            out_found_next = 1'b1;
            out_hw_next    = ent.hw;
          end else begin
            out_found_next = hit;
            out_hw_next    = hw_best;
          end
        end else begin
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
        end
      end
      default: begin
        pend_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    addr      <= addr_next;
    hit       <= hit_next;
    best      <= best_next;
    hw_best   <= hw_best_next;
    out_found <= out_found_next;
    out_hw    <= out_hw_next;
    out_full  <= out_full_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.hw_addr_out = out_hw;
  assign rsp.table_full  = out_full;

  // a request beat is never taken while a response beat is still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && req.ready))
    else $error("request taken while response pending");

  // the entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // compare data is only used the cycle after a ram read was issued
  a_pend_follows_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(ram_re))
    else $error("compare without a preceding table read");

  // a refused append never reports a match
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_full && out_found))
    else $error("table_full and found both set");

endmodule
